// ===== hw/rtl/fdc_pkg.sv =====
// Shared widths, register indexes and types for the full discrete convolution unit.
// No dependencies; imported by every module of the block.
package fdc_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int COEF_W       = 16;
	localparam int PROD_W       = SAMPLE_W + COEF_W;
	localparam int RESULT_W     = 35;
	localparam int TAPCNT_W     = 3;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int IN_TDATA_W   = 16;
	localparam int OUT_TDATA_W  = 40;
	localparam int MAX_TAPS_DEF = 7;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = 3'd1;

	localparam logic [TAPCNT_W-1:0] TAP_COUNT_RESET = 3'd3;

	typedef struct packed {
		logic valid;
		logic last;
	} fdc_item_t;

endpackage

// ===== hw/rtl/full_discrete_convolution_unit.sv =====
// Full discrete convolution unit: FIR filter whose tail is flushed at frame end.
// Top level; depends on fdc_pkg, fdc_cfg, fdc_front and fdc_mac.
//
// Input stream: s_axis_tdata carries a signed Q15 sample, s_axis_tlast marks
// the last sample of a frame. Output stream: m_axis_tdata carries the signed
// 35-bit unscaled sum, m_axis_tlast marks the final result of an input item.
// Every sample gives one result. A sample with tlast gives one result per active
// tap (tap_count, with 0 read as 1): the tail outputs follow on their own, and
// s_axis_tready is low while the tail is produced, one cycle per tail result
// when the receiver keeps up. The delay line is then cleared for the next frame.
// Configuration: cfg_index 0 is tap_count, 1..7 are coef_0..coef_6; cfg_ready
// is always high. Write only while no transfer is in flight.
// After the input transfer the tap products are registered, then their sum, which drives the output.
// One sample is taken per cycle while no tail is produced and the receiver keeps up.
// When the receiver stalls, the two stages fill and then s_axis_tready drops.
// Reset clears the delay line, the pipeline, tap_count to 3 and all
// coefficients to zero.
module full_discrete_convolution_unit import fdc_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] sample
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [34:0] result, [39:35] zero
	output logic                   m_axis_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic signed [COEF_W-1:0]   coef [MAX_TAPS];
	logic [TAPCNT_W-1:0]        taps;
	logic signed [SAMPLE_W-1:0] window [MAX_TAPS];
	fdc_item_t                  item;
	logic                       adv;
	logic signed [RESULT_W-1:0] result;

	assign cfg_ready = 1'b1;

	fdc_cfg #(
		.MAX_TAPS(MAX_TAPS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.coef     (coef),
		.taps     (taps)
	);

	fdc_front #(
		.MAX_TAPS(MAX_TAPS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_sample(s_axis_tdata[SAMPLE_W-1:0]),
		.in_last  (s_axis_tlast),
		.taps     (taps),
		.adv      (adv),
		.window   (window),
		.item     (item)
	);

	fdc_mac #(
		.MAX_TAPS(MAX_TAPS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.window   (window),
		.coef     (coef),
		.adv      (adv),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.result   (result),
		.last     (m_axis_tlast)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, result};

endmodule

// ===== hw/rtl/fdc_cfg.sv =====
// Configuration registers: tap count and tap coefficients.
// Depends on fdc_pkg; gives the active tap count and masked coefficients.
module fdc_cfg import fdc_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	output logic signed [COEF_W-1:0] coef [MAX_TAPS],
	output logic [TAPCNT_W-1:0]      taps
);

	logic [TAPCNT_W-1:0]      tap_count_q;
	logic signed [COEF_W-1:0] coef_q [MAX_TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RESET;
			for (int j = 0; j < MAX_TAPS; j++) begin
				coef_q[j] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == REG_TAP_COUNT) begin
				tap_count_q <= cfg_data[TAPCNT_W-1:0];
			end
			for (int j = 0; j < MAX_TAPS; j++) begin
				if (cfg_index == REG_COEF_0 + CFG_IDX_W'(j)) begin
					coef_q[j] <= cfg_data[COEF_W-1:0];
				end
			end
		end
	end

	always_comb begin
		if (tap_count_q == '0) begin
			taps = TAPCNT_W'(1);
		end else if (tap_count_q > TAPCNT_W'(MAX_TAPS)) begin
			taps = TAPCNT_W'(MAX_TAPS);
		end else begin
			taps = tap_count_q;
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_TAPS; j++) begin
			coef[j] = (TAPCNT_W'(j) < taps) ? coef_q[j] : '0;
		end
	end

endmodule

// ===== hw/rtl/fdc_front.sv =====
// Delay line and tail sequencer: forms the sample window for each result.
// Depends on fdc_pkg; feeds zeros after the last sample of a frame.
module fdc_front import fdc_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] in_sample,
	input  logic                       in_last,
	input  logic [TAPCNT_W-1:0]        taps,
	input  logic                       adv,
	output logic signed [SAMPLE_W-1:0] window [MAX_TAPS],
	output fdc_item_t                  item
);

	localparam int CNT_W = $clog2(MAX_TAPS);

	logic signed [SAMPLE_W-1:0] dly_q [MAX_TAPS-1];
	logic [CNT_W-1:0]           flush_cnt_q;
	logic                       flushing;
	logic                       take;
	logic                       clear;

	assign flushing = (flush_cnt_q != '0);
	assign in_ready = adv && !flushing;
	assign take     = in_valid && in_ready;

	always_comb begin
		window[0] = flushing ? '0 : in_sample;
		for (int j = 1; j < MAX_TAPS; j++) begin
			window[j] = dly_q[j-1];
		end
	end

	always_comb begin
		item.valid = take || (flushing && adv);
		if (flushing) begin
			item.last = (flush_cnt_q == CNT_W'(1));
		end else begin
			item.last = !in_last || (taps == TAPCNT_W'(1));
		end
		clear = in_last && item.last;
		if (flushing) begin
			clear = item.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_cnt_q <= '0;
			for (int j = 0; j < MAX_TAPS - 1; j++) begin
				dly_q[j] <= '0;
			end
		end else begin
			if (item.valid) begin
				if (clear) begin
					for (int j = 0; j < MAX_TAPS - 1; j++) begin
						dly_q[j] <= '0;
					end
				end else begin
					for (int j = 0; j < MAX_TAPS - 1; j++) begin
						dly_q[j] <= window[j];
					end
				end
			end
			if (take && in_last) begin
				flush_cnt_q <= CNT_W'(taps - TAPCNT_W'(1));
			end else if (flushing && adv) begin
				flush_cnt_q <= flush_cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/fdc_mac.sv =====
// Multiply stage and summing stage with per-stage flow control.
// Depends on fdc_pkg; the summing stage is the output register.
module fdc_mac import fdc_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fdc_item_t                  item,
	input  logic signed [SAMPLE_W-1:0] window [MAX_TAPS],
	input  logic signed [COEF_W-1:0]   coef [MAX_TAPS],
	output logic                       adv,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [RESULT_W-1:0] result,
	output logic                       last
);

	logic signed [PROD_W-1:0]   prod_s1 [MAX_TAPS];
	logic                       valid_s1;
	logic                       last_s1;
	logic signed [RESULT_W-1:0] sum_s2;
	logic                       valid_s2;
	logic                       last_s2;
	logic signed [RESULT_W-1:0] acc;
	logic                       adv2;

	assign adv2 = !valid_s2 || out_ready;
	assign adv  = !valid_s1 || adv2;

	always_comb begin
		acc = '0;
		for (int j = 0; j < MAX_TAPS; j++) begin
			acc = acc + RESULT_W'(prod_s1[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				valid_s1 <= item.valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item.valid) begin
			last_s1 <= item.last;
			for (int j = 0; j < MAX_TAPS; j++) begin
				prod_s1[j] <= window[j] * coef[j];
			end
		end
		if (adv2 && valid_s1) begin
			sum_s2  <= acc;
			last_s2 <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign result    = sum_s2;
	assign last      = last_s2;

endmodule

// ===== verif/testbench.sv =====
// Testbench for full_discrete_convolution_unit: directed and random frames against a
// built-in FIR predictor, with random idling and back-pressure on both streams.
// Depends on fdc_pkg and the full_discrete_convolution_unit RTL.
`timescale 1ns / 100ps

module testbench;
	import fdc_pkg::*;

	typedef struct packed {
		logic signed [RESULT_W-1:0] sum;
		logic                       last;
	} conv_out_t;

	typedef logic [6:0][COEF_W-1:0] coef_bank_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // [15:0] sample
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;       // [34:0] result, [39:35] zero
	logic                   m_axis_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	conv_out_t               pending_outputs[$];
	logic [TAPCNT_W-1:0]     tap_shadow = TAP_COUNT_RESET;
	logic signed [COEF_W-1:0]   coef_shadow [7];
	logic signed [SAMPLE_W-1:0] history_shadow [6];

	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	full_discrete_convolution_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("** full_discrete_convolution_unit: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		conv_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_outputs.size() == 0) begin
				$error("unexpected result transfer: result %0d last %0b",
					$signed(m_axis_tdata[RESULT_W-1:0]), m_axis_tlast);
				errors++;
			end else begin
				want = pending_outputs.pop_front();
				if (m_axis_tdata[RESULT_W-1:0] !== want.sum) begin
					$error("result: expected %0d, actual %0d", want.sum,
						$signed(m_axis_tdata[RESULT_W-1:0]));
					errors++;
				end
				if (m_axis_tdata[OUT_TDATA_W-1:RESULT_W] !== '0) begin
					$error("tdata pad: expected 0, actual %0h",
						m_axis_tdata[OUT_TDATA_W-1:RESULT_W]);
					errors++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last_result: expected %0b, actual %0b", want.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// full convolution step: one sum per sample, plus the tail at frame end
	function automatic void convolve(input logic signed [SAMPLE_W-1:0] smp, input logic frame_end);
		logic signed [SAMPLE_W-1:0] hist [7];
		int taps;
		int n_out;
		longint acc;
		conv_out_t item;
		hist[0] = smp;
		for (int j = 1; j < 7; j++)
			hist[j] = history_shadow[j-1];
		taps = (tap_shadow == 0) ? 1 : int'(tap_shadow);
		n_out = frame_end ? taps : 1;
		for (int k = 0; k < n_out; k++) begin
			acc = 0;
			for (int j = k; j < taps; j++)
				acc += longint'(coef_shadow[j]) * longint'(hist[j-k]);
			item.sum = acc[RESULT_W-1:0];
			item.last = (k == n_out - 1);
			pending_outputs.push_back(item);
		end
		for (int j = 0; j < 6; j++)
			history_shadow[j] = frame_end ? '0 : hist[j];
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic frame_end);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		s_axis_tlast <= frame_end;
		do @(posedge clk); while (!s_axis_tready);
		convolve(smp, frame_end);
	endtask

	// drop the input and wait until every expected result has transferred
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_outputs.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_TAP_COUNT)
			tap_shadow = val[TAPCNT_W-1:0];
		else
			coef_shadow[idx - REG_COEF_0] = val;
	endtask

	task automatic set_taps(input logic [TAPCNT_W-1:0] taps);
		logic [CFG_DATA_W-1:0] val;
		val = 16'($urandom);
		val[TAPCNT_W-1:0] = taps;
		write_reg(REG_TAP_COUNT, val);
	endtask

	task automatic program_filter(input logic [TAPCNT_W-1:0] taps, input coef_bank_t bank);
		set_taps(taps);
		for (int j = 0; j < 7; j++)
			write_reg(REG_COEF_0 + CFG_IDX_W'(j), bank[j]);
		cfg_valid <= 1'b0;
	endtask

	task automatic randomize_filter();
		coef_bank_t bank;
		for (int j = 0; j < 7; j++) begin
			case ($urandom_range(9))
				0: bank[j] = 16'h8000;
				1: bank[j] = 16'h7FFF;
				default: bank[j] = 16'($urandom);
			endcase
		end
		program_filter(TAPCNT_W'($urandom_range(7)), bank);
	endtask

	task automatic run_frames(input int count);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 8);
			if (len > count - sent)
				len = count - sent;
			for (int i = 0; i < len; i++)
				send_sample(random_sample(), i == len - 1);
			sent += len;
		end
	endtask

	task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
		settle();
		randomize_filter();
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		run_frames(count);
	endtask

	task automatic test_reset_state();
		send_sample(16'h1234, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7FFF, 1'b1);
	endtask

	task automatic test_extreme_values();
		settle();
		program_filter(3'd7, {7{16'h8000}});
		for (int i = 0; i < 7; i++)
			send_sample(16'h8000, i == 6);
		settle();
		program_filter(3'd7, {7{16'h7FFF}});
		for (int i = 0; i < 3; i++)
			send_sample(16'h8000, i == 2);
	endtask

	task automatic test_tap_count_limits();
		settle();
		program_filter(3'd0, {16'h0001, 16'h8000, 16'h7FFF, 16'h1111,
			16'h2222, 16'h3333, 16'h4000});
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b1);
		settle();
		set_taps(3'd1);
		cfg_valid <= 1'b0;
		send_sample(16'h5A5A, 1'b1);
	endtask

	task automatic test_tap_change_mid_frame();
		settle();
		program_filter(3'd2, {16'hA5A5, 16'h5A5A, 16'h7FFF, 16'h8000,
			16'h0F0F, 16'hF0F0, 16'h4000});
		for (int i = 0; i < 3; i++)
			send_sample(random_sample(), 1'b0);
		settle();
		set_taps(3'd6);
		cfg_valid <= 1'b0;
		send_sample(random_sample(), 1'b0);
		send_sample(random_sample(), 1'b1);
	endtask

	task automatic test_streaming_no_idle();
		run_phase(100, 0, 0);
	endtask

	task automatic test_sender_idle();
		run_phase(80, 88, 0);
	endtask

	task automatic test_receiver_stall();
		run_phase(80, 0, 88);
	endtask

	task automatic test_both_idle();
		run_phase(100, 38, 38);
	endtask

	task automatic test_backpressure();
		settle();
		randomize_filter();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 300;
		run_frames(40);
		settle();
		run_frames(20);
	endtask

	task automatic test_extreme_coefs_random();
		settle();
		program_filter(3'd7, {7{16'h8000}});
		send_idle_pct = 38;
		recv_stall_pct = 38;
		run_frames(20);
		settle();
		program_filter(3'd7, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
			16'h7FFF, 16'h8000, 16'h7FFF});
		run_frames(20);
	endtask

	initial begin
		for (int j = 0; j < 7; j++)
			coef_shadow[j] = '0;
		for (int j = 0; j < 6; j++)
			history_shadow[j] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_extreme_values();
		test_tap_count_limits();
		test_tap_change_mid_frame();
		test_streaming_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_backpressure();
		test_extreme_coefs_random();
		settle();
		repeat (10) @(posedge clk);
		if (pending_outputs.size() != 0) begin
			$error("%0d results never arrived", pending_outputs.size());
			errors++;
		end
		if (errors == 0) begin
			$display("** full_discrete_convolution_unit: PASSED **");
		end else begin
			$display("** full_discrete_convolution_unit: FAILED **");
		end
		$finish;
	end

endmodule
